/* rtl/pidtm_pkg.sv */
// Shared types and constants for the two-mode PID controller.
package pidtm_pkg;

  localparam int unsigned FRAC_BITS = 8;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ERR_W = 16;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned LIM_W = 32;

  typedef enum logic [2:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_OUT_UPPER   = 3'd3,
    REG_OUT_LOWER   = 3'd4,
    REG_INTEG_UPPER = 3'd5,
    REG_INTEG_LOWER = 3'd6,
    REG_CALC_MODE   = 3'd7
  } reg_idx_e;

  typedef enum logic {
    MODE_POSITIONAL  = 1'b0,
    MODE_INCREMENTAL = 1'b1
  } calc_mode_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic signed [LIM_W-1:0]  out_upper;
    logic signed [LIM_W-1:0]  out_lower;
    logic signed [LIM_W-1:0]  integ_upper;
    logic signed [LIM_W-1:0]  integ_lower;
    calc_mode_e               calc_mode;
  } cfg_t;

endpackage

/* rtl/pidtm_regs.sv */
// APB register file holding the controller gains, limits and mode.
module pidtm_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pidtm_pkg::ADDR_W-1:0] paddr,
  input  logic [pidtm_pkg::DATA_W-1:0] pwdata,
  output logic [pidtm_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output pidtm_pkg::cfg_t              cfg_o
);
  import pidtm_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p      <= '0;
      cfg_q.gain_i      <= '0;
      cfg_q.gain_d      <= '0;
      cfg_q.out_upper   <= 32'sd1023;
      cfg_q.out_lower   <= -32'sd1023;
      cfg_q.integ_upper <= 32'sd32767;
      cfg_q.integ_lower <= -32'sd32767;
      cfg_q.calc_mode   <= MODE_INCREMENTAL;
    end else if (wr_en) begin
      case (idx)
        REG_GAIN_P:      cfg_q.gain_p      <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:      cfg_q.gain_i      <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:      cfg_q.gain_d      <= pwdata[GAIN_W-1:0];
        REG_OUT_UPPER:   cfg_q.out_upper   <= pwdata[LIM_W-1:0];
        REG_OUT_LOWER:   cfg_q.out_lower   <= pwdata[LIM_W-1:0];
        REG_INTEG_UPPER: cfg_q.integ_upper <= pwdata[LIM_W-1:0];
        REG_INTEG_LOWER: cfg_q.integ_lower <= pwdata[LIM_W-1:0];
        REG_CALC_MODE:   cfg_q.calc_mode   <= calc_mode_e'(pwdata[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_P:      prdata = DATA_W'(cfg_q.gain_p);
      REG_GAIN_I:      prdata = DATA_W'(cfg_q.gain_i);
      REG_GAIN_D:      prdata = DATA_W'(cfg_q.gain_d);
      REG_OUT_UPPER:   prdata = DATA_W'(cfg_q.out_upper);
      REG_OUT_LOWER:   prdata = DATA_W'(cfg_q.out_lower);
      REG_INTEG_UPPER: prdata = DATA_W'(cfg_q.integ_upper);
      REG_INTEG_LOWER: prdata = DATA_W'(cfg_q.integ_lower);
      REG_CALC_MODE:   prdata = {{(DATA_W-1){1'b0}}, cfg_q.calc_mode};
      default:         prdata = '0;
    endcase
  end

endmodule

/* rtl/pidtm_core.sv */
// PID arithmetic for one error sample plus the controller history registers.
module pidtm_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pidtm_pkg::cfg_t                    cfg_i,
  input  logic                               fire_i,
  input  logic signed [pidtm_pkg::ERR_W-1:0] err_i,
  output logic signed [pidtm_pkg::LIM_W-1:0] drive_o,
  output logic                               clamped_o
);
  import pidtm_pkg::*;

  localparam int unsigned SUM_W = 50;
  localparam int unsigned PRE_W = SUM_W + 1;

  logic signed [LIM_W-1:0] integ_q, integ_d;
  logic signed [ERR_W-1:0] prev1_q, prev2_q;
  logic signed [LIM_W-1:0] out_prev_q;

  logic signed [GAIN_W-1:0] gp, gi, gd;
  logic signed [LIM_W-1:0]  ou, ol, iu, il;
  logic                     incr;

  logic signed [ERR_W:0]   diff1;
  logic signed [ERR_W+2:0] diff2;
  logic signed [LIM_W:0]   integ_sum;

  logic signed [ERR_W:0]   op_a;
  logic signed [ERR_W+2:0] op_b;
  logic signed [LIM_W-1:0] op_c;
  logic signed [ERR_W+GAIN_W:0]   prod_a;
  logic signed [ERR_W+GAIN_W+2:0] prod_b;
  logic signed [LIM_W+GAIN_W-1:0] prod_c;

  logic signed [SUM_W-1:0] sum, scaled;
  logic signed [PRE_W-1:0] pre;

  assign gp   = cfg_i.gain_p;
  assign gi   = cfg_i.gain_i;
  assign gd   = cfg_i.gain_d;
  assign ou   = cfg_i.out_upper;
  assign ol   = cfg_i.out_lower;
  assign iu   = cfg_i.integ_upper;
  assign il   = cfg_i.integ_lower;
  assign incr = (cfg_i.calc_mode == MODE_INCREMENTAL);

  always_comb begin
    diff1 = (ERR_W+1)'(err_i) - (ERR_W+1)'(prev1_q);
    diff2 = (ERR_W+3)'(err_i) - ((ERR_W+3)'(prev1_q) <<< 1) + (ERR_W+3)'(prev2_q);

    // cap to the upper limit first, then raise to the lower one
    integ_sum = (LIM_W+1)'(integ_q) + (LIM_W+1)'(err_i);
    integ_d   = integ_sum[LIM_W-1:0];
    if (integ_sum > (LIM_W+1)'(iu)) integ_d = iu;
    if ((integ_sum < (LIM_W+1)'(il)) || (iu < il)) integ_d = il;

    // three multipliers shared between the two forms
    if (incr) begin
      op_a = diff1;
      op_b = diff2;
      op_c = LIM_W'(err_i);
    end else begin
      op_a = (ERR_W+1)'(err_i);
      op_b = (ERR_W+3)'(diff1);
      op_c = integ_d;
    end
    prod_a = op_a * gp;
    prod_b = op_b * gd;
    prod_c = op_c * gi;

    sum    = SUM_W'(prod_a) + SUM_W'(prod_b) + SUM_W'(prod_c);
    scaled = sum >>> FRAC_BITS;
    pre    = PRE_W'(scaled) + (incr ? PRE_W'(out_prev_q) : PRE_W'(0));

    clamped_o = (pre > PRE_W'(ou)) || (pre < PRE_W'(ol));
    drive_o   = pre[LIM_W-1:0];
    if (pre > PRE_W'(ou)) drive_o = ou;
    if ((pre < PRE_W'(ol)) || (ou < ol)) drive_o = ol;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      prev1_q    <= '0;
      prev2_q    <= '0;
      out_prev_q <= '0;
    end else if (fire_i) begin
      prev1_q <= err_i;
      if (incr) begin
        prev2_q    <= prev1_q;
        out_prev_q <= drive_o;
      end else begin
        integ_q <= integ_d;
      end
    end
  end

endmodule

/* rtl/pid_controller_two_mode_unit.sv */
// Top level of the two-mode PID controller: handshake, input and result registers.
//
//   channel  direction  handshake                   payload
//   in       input      in_valid_i / in_stall_o     err_sample_i
//   out      output     out_valid_o / out_stall_i   drive_value_o, clamped_o
//   cfg      APB        psel, penable, pwrite       paddr, pwdata, prdata
//
// One error sample per cycle sustained while out_stall_i is low; each sample
// passes through the input register, then the result register, before
// out_valid_o rises.
// The controller history is updated as a sample moves into the result
// register, so consecutive samples see each other's state without bubbles.
// Reset clears the history, sets the register defaults and empties both
// stages. A stall on the output holds the result; one more sample is held
// in the input register before in_stall_o rises.
module pid_controller_two_mode_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [pidtm_pkg::ERR_W-1:0]  err_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pidtm_pkg::LIM_W-1:0]  drive_value_o,
  output logic                                clamped_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pidtm_pkg::ADDR_W-1:0]        paddr,
  input  logic [pidtm_pkg::DATA_W-1:0]        pwdata,
  output logic [pidtm_pkg::DATA_W-1:0]        prdata,
  output logic                                pready
);
  import pidtm_pkg::*;

  cfg_t cfg;

  logic                    in_vld_q;
  logic signed [ERR_W-1:0] err_q;
  logic                    out_vld_q;
  logic signed [LIM_W-1:0] drive_q, drive_d;
  logic                    clamped_q, clamped_d;
  logic                    advance, accept;

  pidtm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pidtm_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .fire_i    (advance),
    .err_i     (err_q),
    .drive_o   (drive_d),
    .clamped_o (clamped_d)
  );

  // move the held sample on whenever the result register is free or draining
  assign advance    = in_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = in_vld_q & ~advance;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q <= err_sample_i;
    end
    if (advance) begin
      drive_q   <= drive_d;
      clamped_q <= clamped_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign drive_value_o = drive_q;
  assign clamped_o     = clamped_q;

endmodule

/* tb/sv/pid_controller_two_mode_unit_tb.sv */
// Self-checking testbench for the two-mode PID controller unit.
module pid_controller_two_mode_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pidtm_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 50;

  typedef struct {
    logic signed [LIM_W-1:0] drive;
    logic                    clamped;
  } drive_exp_t;

  // Tracks controller state and configuration, predicts each drive value.
  class pid_drive_model;
    cfg_t                    cfg;
    logic signed [LIM_W-1:0] integ;
    logic signed [ERR_W-1:0] prev1;
    logic signed [ERR_W-1:0] prev2;
    logic signed [LIM_W-1:0] out_prev;
    drive_exp_t              expected[$];
    int                      failures;

    function new();
      cfg.gain_p      = '0;
      cfg.gain_i      = '0;
      cfg.gain_d      = '0;
      cfg.out_upper   = 1023;
      cfg.out_lower   = -1023;
      cfg.integ_upper = 32767;
      cfg.integ_lower = -32767;
      cfg.calc_mode   = MODE_INCREMENTAL;
      integ    = '0;
      prev1    = '0;
      prev2    = '0;
      out_prev = '0;
      failures = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_GAIN_P:      cfg.gain_p      = val[GAIN_W-1:0];
        REG_GAIN_I:      cfg.gain_i      = val[GAIN_W-1:0];
        REG_GAIN_D:      cfg.gain_d      = val[GAIN_W-1:0];
        REG_OUT_UPPER:   cfg.out_upper   = val[LIM_W-1:0];
        REG_OUT_LOWER:   cfg.out_lower   = val[LIM_W-1:0];
        REG_INTEG_UPPER: cfg.integ_upper = val[LIM_W-1:0];
        REG_INTEG_LOWER: cfg.integ_lower = val[LIM_W-1:0];
        REG_CALC_MODE:   cfg.calc_mode   = calc_mode_e'(val[0]);
        default: ;
      endcase
    endfunction

    // Cap to hi first, then raise to lo: inverted limits yield lo.
    function longint clip(longint v, longint lo, longint hi, output bit hit);
      hit = (v > hi) || (v < lo);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v;
    endfunction

    function void note_sample(logic signed [ERR_W-1:0] err);
      longint     e;
      longint     sum;
      longint     drive;
      bit         hit;
      bit         unused;
      drive_exp_t x;
      e = longint'(err);
      if (cfg.calc_mode == MODE_POSITIONAL) begin
        integ = LIM_W'(clip(integ + e, cfg.integ_lower, cfg.integ_upper, unused));
        sum = e * cfg.gain_p + (e - prev1) * cfg.gain_d + integ * cfg.gain_i;
        drive = clip(sum >>> FRAC_BITS, cfg.out_lower, cfg.out_upper, hit);
        prev1 = err;
      end else begin
        sum = (e - prev1) * cfg.gain_p
            + (e - 2 * prev1 + prev2) * cfg.gain_d
            + e * cfg.gain_i;
        drive = clip((sum >>> FRAC_BITS) + out_prev, cfg.out_lower, cfg.out_upper, hit);
        prev2    = prev1;
        prev1    = err;
        out_prev = drive[LIM_W-1:0];
      end
      x.drive   = drive[LIM_W-1:0];
      x.clamped = hit;
      expected.push_back(x);
    endfunction

    function void check_drive(logic signed [LIM_W-1:0] drive, logic clamped);
      drive_exp_t x;
      if (expected.size() == 0) begin
        $error("unexpected drive result %0d clamped %0b", drive, clamped);
        failures++;
        return;
      end
      x = expected.pop_front();
      if (drive !== x.drive) begin
        $error("drive_value expected %0d actual %0d", x.drive, drive);
        failures++;
      end
      if (clamped !== x.clamped) begin
        $error("clamped expected %0b actual %0b", x.clamped, clamped);
        failures++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [ERR_W-1:0] err_sample_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [LIM_W-1:0] drive_value_o;
  logic                    clamped_o;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  pid_drive_model model = new();

  int burst_left = 0;
  int stall_left = 0;
  int stall_kind = 0;
  int stall_tick = 0;
  int idle_cycles = 0;

  pid_controller_two_mode_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .err_sample_i  (err_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .drive_value_o (drive_value_o),
    .clamped_o     (clamped_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver stall pattern: segments of no stall, light, heavy and periodic stall.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 3);
      stall_left = $urandom_range(5, 80);
    end
    stall_left--;
    stall_tick++;
    case (stall_kind)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= (stall_tick % 5) < 2;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      model.check_drive(drive_value_o, clamped_o);
  end

  // Watchdog: count cycles with no request accepted anywhere.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("pid_controller_two_mode_unit verification failed");
      $finish;
    end
  end

  // Start at a falling edge; return at a falling edge with the bus still selected.
  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    model.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic write_config(input logic [15:0] kp, input logic [15:0] ki,
                              input logic [15:0] kd, input logic [31:0] ou,
                              input logic [31:0] ol, input logic [31:0] iu,
                              input logic [31:0] il, input calc_mode_e mode);
    write_reg(REG_GAIN_P, {16'h0, kp});
    write_reg(REG_GAIN_I, {16'h0, ki});
    write_reg(REG_GAIN_D, {16'h0, kd});
    write_reg(REG_OUT_UPPER, ou);
    write_reg(REG_OUT_LOWER, ol);
    write_reg(REG_INTEG_UPPER, iu);
    write_reg(REG_INTEG_LOWER, il);
    write_reg(REG_CALC_MODE, {31'h0, mode});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Send one error sample; bursts of random length with random gaps in between.
  task automatic send_sample(input logic signed [ERR_W-1:0] e);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    err_sample_i <= e;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    model.note_sample(e);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted drive value has arrived.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (model.pending() != 0) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom_range(0, 1024) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic pick_limits(output logic [31:0] hi, output logic [31:0] lo);
    case ($urandom_range(0, 4))
      0: begin
        hi = 32'h7FFF_FFFF;
        lo = 32'h8000_0000;
      end
      1, 2: begin
        hi = $urandom_range(0, 100000);
        lo = -$urandom_range(0, 100000);
      end
      3: begin
        hi = $urandom;
        lo = $urandom;
      end
      default: begin
        hi = -$urandom_range(0, 500);
        lo = $urandom_range(0, 500);
      end
    endcase
  endtask

  function automatic logic [15:0] rand_err();
    case ($urandom_range(0, 19))
      0:                return 16'h7FFF;
      1:                return 16'h8000;
      2:                return 16'h0000;
      3, 4, 5, 6, 7:    return 16'($urandom_range(0, 64) - 32);
      default:          return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [31:0] ou, ol, iu, il;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Positional form, moderate gains, integral clamp reachable.
    write_config(16'h0100, 16'h0080, 16'hFFC0, 32'd1023, -32'sd1023,
                 32'd40000, -32'sd40000, MODE_POSITIONAL);
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    send_sample(-16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sh0001);
    send_sample(16'sh0001);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    drain();

    // Incremental form, extreme gains, widest output limits.
    write_config(16'h7FFF, 16'h8000, 16'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, MODE_INCREMENTAL);
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh0000);
    drain();

    // Inverted output and integral limits: the lower limit wins.
    write_config(16'h0100, 16'h0100, 16'h0100, -32'sd5, 32'd5,
                 -32'sd100, 32'd100, MODE_POSITIONAL);
    send_sample(16'sd100);
    send_sample(-16'sd100);
    send_sample(16'sd0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      pick_limits(ou, ol);
      pick_limits(iu, il);
      write_config(rand_gain(), rand_gain(), rand_gain(), ou, ol, iu, il,
                   calc_mode_e'($urandom_range(0, 1)));
      for (int k = 0; k < PHASE_LEN; k++) send_sample(rand_err());
      drain();
    end

    repeat (8) @(negedge clk_i);
    if (model.failures == 0 && model.pending() == 0)
      $display("pid_controller_two_mode_unit verification clean");
    else
      $display("pid_controller_two_mode_unit verification failed");
    $finish;
  end

endmodule
